// ===== hdl/afl_pkg.sv =====
// types, codes and bit masks shared by the fast-load transceiver modules
package afl_pkg;

  // command codes carried in the cmd field
  typedef enum logic [1:0] {
    CmdTick    = 2'd0,
    CmdTxBlock = 2'd1,
    CmdData    = 2'd2,
    CmdRxByte  = 2'd3
  } cmd_e;

  typedef enum logic [8:0] {
    ModeIdle   = 9'b000000001,
    ModeRxPull = 9'b000000010,
    ModeRxRel  = 9'b000000100,
    ModeTxWait = 9'b000001000,
    ModeTxLen  = 9'b000010000,
    ModeTxMark = 9'b000100000,
    ModeTxData = 9'b001000000,
    ModeTxNeed = 9'b010000000,
    ModeTxEnd  = 9'b100000000
  } mode_e;

  localparam logic [7:0] SettleReset = 8'd2;

  // inverted-byte bits put on clock and data in each of the four send phases
  localparam logic [7:0] ClkMask  [4] = '{8'h80, 8'h40, 8'h08, 8'h04};
  localparam logic [7:0] DataMask [4] = '{8'h20, 8'h10, 8'h02, 8'h01};

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] tx_byte;
    logic [7:0] block_marker;
    logic [7:0] block_length;
    logic       atn_level;
    logic       clk_level;
    logic       data_level;
    logic       reset_idle;
  } in_t;

  typedef struct packed {
    logic       clk_release;
    logic       data_release;
    logic [7:0] rx_value;
    logic       rx_valid;
    logic       need_data;
    logic       block_done;
    logic       aborted;
    logic       busy_res;
  } out_t;

endpackage

// ===== hdl/afl_core.sv =====
// protocol state machine: takes one line sample per step and forms its result
module afl_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  afl_pkg::in_t   item_i,
  input  logic [7:0]     settle_i,
  output afl_pkg::out_t  res_o
);

  afl_pkg::mode_e mode_q, mode_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] settle_q, settle_d;
  logic [1:0] phase_q, phase_d;
  logic [7:0] left_q, left_d;
  logic [7:0] marker_q, marker_d;
  logic       clk_drv_q, clk_drv_d;
  logic       data_drv_q, data_drv_d;

  logic       rx_valid, done, aborted, abort_tx, byte_sent;
  logic [7:0] inv;

  always_comb begin
    mode_d     = mode_q;
    bit_d      = bit_q;
    shift_d    = shift_q;
    settle_d   = settle_q;
    phase_d    = phase_q;
    left_d     = left_q;
    marker_d   = marker_q;
    clk_drv_d  = clk_drv_q;
    data_drv_d = data_drv_q;
    rx_valid   = 1'b0;
    done       = 1'b0;
    aborted    = 1'b0;
    abort_tx   = 1'b0;
    byte_sent  = 1'b0;
    inv        = ~shift_q;

    if (mode_q == afl_pkg::ModeIdle && item_i.cmd == afl_pkg::CmdTxBlock) begin
      marker_d   = item_i.block_marker;
      left_d     = item_i.block_length;
      clk_drv_d  = 1'b1;
      data_drv_d = 1'b1;
      phase_d    = 2'd0;
      mode_d     = afl_pkg::ModeTxWait;
    end else if (mode_q == afl_pkg::ModeIdle && item_i.cmd == afl_pkg::CmdRxByte) begin
      bit_d      = 3'd0;
      shift_d    = 8'd0;
      clk_drv_d  = 1'b1;
      data_drv_d = 1'b1;
      settle_d   = settle_i;
      mode_d     = afl_pkg::ModeRxPull;
    end else if (mode_q == afl_pkg::ModeTxNeed && item_i.cmd == afl_pkg::CmdData) begin
      shift_d = item_i.tx_byte;
      left_d  = left_q - 8'd1;
      phase_d = 2'd0;
      mode_d  = afl_pkg::ModeTxData;
    end else begin
      case (mode_q)
        afl_pkg::ModeIdle: begin
        end
        afl_pkg::ModeRxPull: begin
          if (settle_q != 8'd0) begin
            settle_d = settle_q - 8'd1;
          end else if (!item_i.atn_level || !item_i.reset_idle) begin
            mode_d  = afl_pkg::ModeIdle;
            aborted = 1'b1;
          end else if (!item_i.clk_level || !item_i.data_level) begin
            // data low carries a one; acknowledge on the other line
            shift_d = {~item_i.data_level, shift_q[7:1]};
            if (item_i.data_level) begin
              data_drv_d = 1'b0;
            end else begin
              clk_drv_d = 1'b0;
            end
            settle_d = settle_i;
            mode_d   = afl_pkg::ModeRxRel;
          end
        end
        afl_pkg::ModeRxRel: begin
          if (settle_q != 8'd0) begin
            settle_d = settle_q - 8'd1;
          end else if (!item_i.atn_level || !item_i.reset_idle) begin
            mode_d  = afl_pkg::ModeIdle;
            aborted = 1'b1;
          end else if (item_i.clk_level || item_i.data_level) begin
            if (bit_q == 3'd7) begin
              bit_d    = 3'd0;
              rx_valid = 1'b1;
              mode_d   = afl_pkg::ModeIdle;
            end else begin
              bit_d      = bit_q + 3'd1;
              clk_drv_d  = 1'b1;
              data_drv_d = 1'b1;
              settle_d   = settle_i;
              mode_d     = afl_pkg::ModeRxPull;
            end
          end
        end
        afl_pkg::ModeTxWait: begin
          if (!item_i.atn_level) begin
            clk_drv_d  = 1'b0;
            data_drv_d = 1'b0;
            shift_d    = left_q + 8'd2;
            phase_d    = 2'd0;
            mode_d     = afl_pkg::ModeTxLen;
          end else if (!item_i.reset_idle) begin
            mode_d  = afl_pkg::ModeIdle;
            aborted = 1'b1;
          end
        end
        afl_pkg::ModeTxLen, afl_pkg::ModeTxMark, afl_pkg::ModeTxData: begin
          // even phases wait for attention high, odd ones for low
          if (item_i.atn_level == ~phase_q[0]) begin
            clk_drv_d  = |(inv & afl_pkg::ClkMask[phase_q]);
            data_drv_d = |(inv & afl_pkg::DataMask[phase_q]);
            if (phase_q == 2'd3) begin
              phase_d   = 2'd0;
              byte_sent = 1'b1;
            end else begin
              phase_d = phase_q + 2'd1;
            end
          end else if (!item_i.reset_idle) begin
            abort_tx = 1'b1;
          end
          if (byte_sent) begin
            if (mode_q == afl_pkg::ModeTxLen) begin
              shift_d = marker_q;
              mode_d  = afl_pkg::ModeTxMark;
            end else if (left_q != 8'd0) begin
              mode_d = afl_pkg::ModeTxNeed;
            end else begin
              mode_d = afl_pkg::ModeTxEnd;
            end
          end
        end
        afl_pkg::ModeTxNeed: begin
          if (!item_i.reset_idle) begin
            abort_tx = 1'b1;
          end
        end
        afl_pkg::ModeTxEnd: begin
          if (item_i.atn_level) begin
            clk_drv_d  = 1'b0;
            data_drv_d = 1'b0;
            mode_d     = afl_pkg::ModeIdle;
            done       = 1'b1;
          end else if (!item_i.reset_idle) begin
            abort_tx = 1'b1;
          end
        end
        default: begin
          mode_d = afl_pkg::ModeIdle;
        end
      endcase
      if (abort_tx) begin
        clk_drv_d  = 1'b0;
        data_drv_d = 1'b0;
        mode_d     = afl_pkg::ModeIdle;
        aborted    = 1'b1;
      end
    end
  end

  always_comb begin
    res_o.clk_release  = clk_drv_d;
    res_o.data_release = data_drv_d;
    res_o.rx_value     = rx_valid ? shift_q : 8'd0;
    res_o.rx_valid     = rx_valid;
    res_o.need_data    = (mode_d == afl_pkg::ModeTxNeed);
    res_o.block_done   = done;
    res_o.aborted      = aborted;
    res_o.busy_res     = (mode_d != afl_pkg::ModeIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= afl_pkg::ModeIdle;
      bit_q      <= 3'd0;
      shift_q    <= 8'd0;
      settle_q   <= 8'd0;
      phase_q    <= 2'd0;
      left_q     <= 8'd0;
      marker_q   <= 8'd0;
      clk_drv_q  <= 1'b1;
      data_drv_q <= 1'b1;
    end else if (step_i) begin
      mode_q     <= mode_d;
      bit_q      <= bit_d;
      shift_q    <= shift_d;
      settle_q   <= settle_d;
      phase_q    <= phase_d;
      left_q     <= left_d;
      marker_q   <= marker_d;
      clk_drv_q  <= clk_drv_d;
      data_drv_q <= data_drv_d;
    end
  end

endmodule

// ===== hdl/atn_clocked_fastload_transceiver.sv =====
// Device-side fast-load transceiver: one sampled line set per input beat.
// Input channel (in_valid_i/in_ready_o, in_i) carries a command and the
// sampled attention, clock, data and bus-reset levels. Command tick only
// samples; tx-block starts a frame; data supplies the next byte while
// need_data is set; rx-byte starts receiving one byte LSB first.
// Output channel (out_valid_o/out_ready_i, out_o) returns exactly one result
// beat per input beat: line drives, received byte, and status pulses.
// cfg_we_i/cfg_wdata_i write the settle sample count (reset value 2); write
// it only while the block is idle.
// A beat is held in the input register, then the state machine step loads its
// result into the output register, from which it is offered. Throughput is
// one beat per cycle while the output is taken, set by the single state
// machine step between the two registers.
// Reset releases both lines and returns to idle. When the receiver stalls,
// the output register holds its beat, the input register fills, and
// in_ready_o drops until the output is taken; no beat is lost.
module atn_clocked_fastload_transceiver (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  afl_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output afl_pkg::out_t out_o,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_wdata_i
);

  afl_pkg::in_t  in_q;
  afl_pkg::out_t out_q, res;
  logic          in_valid_q, out_valid_q;
  logic [7:0]    settle_q;
  logic          advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  afl_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .settle_i (settle_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= afl_pkg::SettleReset;
    end else if (cfg_we_i) begin
      settle_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for the fast-load transceiver: protocol predictor, random partner, scoreboard
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CycleLimit = 200000;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  afl_pkg::in_t  in_i;
  logic          out_valid_o;
  logic          out_ready_i;
  afl_pkg::out_t out_o;
  logic          cfg_we_i;
  logic [7:0]    cfg_wdata_i;

  atn_clocked_fastload_transceiver dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_i,
    .out_valid_o,
    .out_ready_i,
    .out_o,
    .cfg_we_i,
    .cfg_wdata_i
  );

  // link predictor state
  afl_pkg::mode_e lk_mode   = afl_pkg::ModeIdle;
  logic [2:0]     lk_bit    = '0;
  logic [7:0]     lk_shift  = '0;
  logic [7:0]     lk_settle = '0;
  logic [1:0]     lk_phase  = '0;
  logic [7:0]     lk_left   = '0;
  logic [7:0]     lk_marker = '0;
  logic           lk_clk    = 1'b1;
  logic           lk_dat    = 1'b1;
  logic [7:0]     settle_cfg = afl_pkg::SettleReset;

  afl_pkg::out_t line_results_q[$];
  afl_pkg::out_t want;
  int unsigned errors;
  int unsigned n_checked;
  int unsigned n_rx_bytes;
  int unsigned n_frames;
  int unsigned n_aborts;
  int unsigned cycles;
  int          burst_left;
  bit          gaps_on = 1'b1;
  int          hold_left;
  int unsigned sink_cyc;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycles,
             line_results_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // one line sample through the link protocol
  function automatic afl_pkg::out_t link_step(afl_pkg::in_t it);
    afl_pkg::out_t r;
    logic          abort_now;
    logic [7:0]    inv;
    int            ci;
    r = '0;
    abort_now = 1'b0;
    if (lk_mode == afl_pkg::ModeIdle && it.cmd == afl_pkg::CmdTxBlock) begin
      lk_marker = it.block_marker;
      lk_left   = it.block_length;
      lk_clk    = 1'b1;
      lk_dat    = 1'b1;
      lk_phase  = '0;
      lk_mode   = afl_pkg::ModeTxWait;
    end else if (lk_mode == afl_pkg::ModeIdle && it.cmd == afl_pkg::CmdRxByte) begin
      lk_bit    = '0;
      lk_shift  = '0;
      lk_clk    = 1'b1;
      lk_dat    = 1'b1;
      lk_settle = settle_cfg;
      lk_mode   = afl_pkg::ModeRxPull;
    end else if (lk_mode == afl_pkg::ModeTxNeed && it.cmd == afl_pkg::CmdData) begin
      lk_shift = it.tx_byte;
      lk_left  = lk_left - 8'd1;
      lk_phase = '0;
      lk_mode  = afl_pkg::ModeTxData;
    end else begin
      case (lk_mode)
        afl_pkg::ModeIdle: ;
        afl_pkg::ModeRxPull: begin
          if (lk_settle != 0) begin
            lk_settle--;
          end else if (!it.atn_level || !it.reset_idle) begin
            lk_mode   = afl_pkg::ModeIdle;
            r.aborted = 1'b1;
          end else if (!it.clk_level || !it.data_level) begin
            lk_shift = {~it.data_level, lk_shift[7:1]};
            if (it.data_level) lk_dat = 1'b0;
            else lk_clk = 1'b0;
            lk_settle = settle_cfg;
            lk_mode   = afl_pkg::ModeRxRel;
          end
        end
        afl_pkg::ModeRxRel: begin
          if (lk_settle != 0) begin
            lk_settle--;
          end else if (!it.atn_level || !it.reset_idle) begin
            lk_mode   = afl_pkg::ModeIdle;
            r.aborted = 1'b1;
          end else if (it.clk_level || it.data_level) begin
            if (lk_bit == 3'd7) begin
              lk_bit     = '0;
              r.rx_valid = 1'b1;
              r.rx_value = lk_shift;
              lk_mode    = afl_pkg::ModeIdle;
            end else begin
              lk_bit++;
              lk_clk    = 1'b1;
              lk_dat    = 1'b1;
              lk_settle = settle_cfg;
              lk_mode   = afl_pkg::ModeRxPull;
            end
          end
        end
        afl_pkg::ModeTxWait: begin
          if (!it.atn_level) begin
            lk_clk   = 1'b0;
            lk_dat   = 1'b0;
            lk_shift = lk_left + 8'd2;
            lk_phase = '0;
            lk_mode  = afl_pkg::ModeTxLen;
          end else if (!it.reset_idle) begin
            lk_mode   = afl_pkg::ModeIdle;
            r.aborted = 1'b1;
          end
        end
        afl_pkg::ModeTxLen, afl_pkg::ModeTxMark, afl_pkg::ModeTxData: begin
          inv = ~lk_shift;
          // clock carries bits 7,6,3,2 and data the bits two below
          ci = (lk_phase[1] ? 3 : 7) - lk_phase[0];
          if (it.atn_level == ~lk_phase[0]) begin
            lk_clk = inv[ci];
            lk_dat = inv[ci-2];
            if (lk_phase == 2'd3) begin
              lk_phase = '0;
              if (lk_mode == afl_pkg::ModeTxLen) begin
                lk_shift = lk_marker;
                lk_mode  = afl_pkg::ModeTxMark;
              end else begin
                lk_mode = (lk_left != 0) ? afl_pkg::ModeTxNeed : afl_pkg::ModeTxEnd;
              end
            end else begin
              lk_phase++;
            end
          end else if (!it.reset_idle) begin
            abort_now = 1'b1;
          end
        end
        afl_pkg::ModeTxNeed: if (!it.reset_idle) abort_now = 1'b1;
        afl_pkg::ModeTxEnd: begin
          if (it.atn_level) begin
            lk_clk       = 1'b0;
            lk_dat       = 1'b0;
            lk_mode      = afl_pkg::ModeIdle;
            r.block_done = 1'b1;
          end else if (!it.reset_idle) begin
            abort_now = 1'b1;
          end
        end
        default: lk_mode = afl_pkg::ModeIdle;
      endcase
      if (abort_now) begin
        lk_clk    = 1'b0;
        lk_dat    = 1'b0;
        lk_mode   = afl_pkg::ModeIdle;
        r.aborted = 1'b1;
      end
    end
    r.clk_release  = lk_clk;
    r.data_release = lk_dat;
    r.need_data    = (lk_mode == afl_pkg::ModeTxNeed);
    r.busy_res     = (lk_mode != afl_pkg::ModeIdle);
    return r;
  endfunction

  function automatic afl_pkg::in_t rand_sample();
    afl_pkg::in_t it;
    logic [31:0]  raw;
    raw = $urandom;
    it  = raw[$bits(afl_pkg::in_t)-1:0];
    if (it.block_length == 8'hff) it.block_length = 8'($urandom_range(0, 254));
    return it;
  endfunction

  function automatic afl_pkg::in_t mk(afl_pkg::cmd_e c, logic atn, logic cl, logic dt,
                                      logic rs);
    afl_pkg::in_t it;
    it = rand_sample();
    it.cmd        = c;
    it.atn_level  = atn;
    it.clk_level  = cl;
    it.data_level = dt;
    it.reset_idle = rs;
    return it;
  endfunction

  // partner behavior: mostly what the current protocol step waits for, some noise
  function automatic afl_pkg::in_t next_beat();
    afl_pkg::in_t it;
    int unsigned  roll;
    it = rand_sample();
    roll = $urandom_range(0, 99);
    if (roll < 3) return it;
    it.reset_idle = $urandom_range(0, 49) != 0;
    case (lk_mode)
      afl_pkg::ModeIdle: begin
        if (roll < 48) it.cmd = afl_pkg::CmdRxByte;
        else if (roll < 94) it.cmd = afl_pkg::CmdTxBlock;
        else it.cmd = $urandom_range(0, 1) ? afl_pkg::CmdTick : afl_pkg::CmdData;
        if ($urandom_range(0, 49) != 0) it.block_length = 8'($urandom_range(0, 3));
      end
      afl_pkg::ModeRxPull, afl_pkg::ModeRxRel: begin
        if (lk_settle == 0) begin
          it.atn_level = $urandom_range(0, 49) != 0;
          if (lk_mode == afl_pkg::ModeRxPull && it.clk_level && it.data_level
              && roll < 70) begin
            if ($urandom_range(0, 1)) it.clk_level = 1'b0;
            else it.data_level = 1'b0;
          end else if (lk_mode == afl_pkg::ModeRxRel && !it.clk_level && !it.data_level
                       && roll < 70) begin
            if ($urandom_range(0, 1)) it.clk_level = 1'b1;
            else it.data_level = 1'b1;
          end
        end
      end
      afl_pkg::ModeTxWait: it.atn_level = $urandom_range(0, 3) == 0;
      afl_pkg::ModeTxLen, afl_pkg::ModeTxMark, afl_pkg::ModeTxData:
        it.atn_level = (roll < 90) ? ~lk_phase[0] : lk_phase[0];
      afl_pkg::ModeTxNeed: if (roll < 85) it.cmd = afl_pkg::CmdData;
      afl_pkg::ModeTxEnd: it.atn_level = $urandom_range(0, 3) != 0;
      default: ;
    endcase
    return it;
  endfunction

  // a sample that ends whatever transfer is running
  function automatic afl_pkg::in_t abort_beat();
    afl_pkg::in_t it;
    it = mk(afl_pkg::CmdTick, 1'b0, 1'($urandom), 1'($urandom), 1'b0);
    case (lk_mode)
      afl_pkg::ModeTxWait: it.atn_level = 1'b1;
      afl_pkg::ModeTxLen, afl_pkg::ModeTxMark, afl_pkg::ModeTxData:
        it.atn_level = lk_phase[0];
      default: ;
    endcase
    return it;
  endfunction

  task automatic push_beat(input afl_pkg::in_t it);
    if (burst_left == 0) begin
      if (gaps_on) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    in_i       <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    line_results_q.push_back(link_step(it));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (line_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_settle(input logic [7:0] v);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    settle_cfg = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_traffic(input int n);
    afl_pkg::in_t it;
    int           k;
    k = 0;
    while (k < n) begin
      it = next_beat();
      if (lk_mode != afl_pkg::ModeIdle || it.cmd == afl_pkg::CmdTxBlock
          || it.cmd == afl_pkg::CmdRxByte) k++;
      push_beat(it);
    end
    // wind down to idle so the next setting is written between transfers
    while (lk_mode != afl_pkg::ModeIdle)
      push_beat(lk_settle != 0 ? next_beat() : abort_beat());
  endtask

  task automatic test_default_settle();
    run_traffic(120);
  endtask

  task automatic test_directed();
    afl_pkg::in_t it;
    write_settle(8'd0);
    // start sample is not looked at, then a one bit, a busy start, a zero bit
    push_beat(mk(afl_pkg::CmdRxByte, 1'b0, 1'b0, 1'b0, 1'b0));
    push_beat(mk(afl_pkg::CmdTick, 1'b1, 1'b1, 1'b0, 1'b1));
    push_beat(mk(afl_pkg::CmdTxBlock, 1'b1, 1'b1, 1'b1, 1'b1));
    push_beat(mk(afl_pkg::CmdTick, 1'b1, 1'b0, 1'b1, 1'b1));
    push_beat(mk(afl_pkg::CmdRxByte, 1'b1, 1'b1, 1'b0, 1'b1));
    push_beat(mk(afl_pkg::CmdTick, 1'b0, 1'b1, 1'b1, 1'b1));
    // bus reset during a receive
    push_beat(mk(afl_pkg::CmdRxByte, 1'b1, 1'b1, 1'b1, 1'b1));
    push_beat(mk(afl_pkg::CmdTick, 1'b1, 1'b0, 1'b0, 1'b0));
    // length 254 wraps to zero, reset after the frame started pulls both lines
    it = mk(afl_pkg::CmdTxBlock, 1'b1, 1'b1, 1'b1, 1'b1);
    it.block_length = 8'd254;
    it.block_marker = 8'hff;
    push_beat(it);
    push_beat(mk(afl_pkg::CmdTick, 1'b0, 1'b1, 1'b1, 1'b1));
    push_beat(mk(afl_pkg::CmdTick, 1'b1, 1'b1, 1'b1, 1'b1));
    push_beat(mk(afl_pkg::CmdTick, 1'b1, 1'b1, 1'b1, 1'b0));
    // reset before the frame starts leaves lines released
    push_beat(mk(afl_pkg::CmdTxBlock, 1'b1, 1'b0, 1'b0, 1'b1));
    push_beat(mk(afl_pkg::CmdTick, 1'b1, 1'b1, 1'b1, 1'b0));
    // complete frame: one data byte, last-block marker
    it = mk(afl_pkg::CmdTxBlock, 1'b1, 1'b1, 1'b1, 1'b1);
    it.block_length = 8'd1;
    it.block_marker = 8'd1;
    push_beat(it);
    push_beat(mk(afl_pkg::CmdTick, 1'b0, 1'b1, 1'b1, 1'b1));
    for (int i = 0; i < 8; i++) push_beat(mk(afl_pkg::CmdTick, ~i[0], 1'b1, 1'b1, 1'b1));
    it = mk(afl_pkg::CmdData, 1'b0, 1'b0, 1'b0, 1'b1);
    it.tx_byte = 8'h00;
    push_beat(it);
    for (int i = 0; i < 4; i++) push_beat(mk(afl_pkg::CmdTick, ~i[0], 1'b1, 1'b1, 1'b1));
    push_beat(mk(afl_pkg::CmdTick, 1'b1, 1'b1, 1'b1, 1'b1));
  endtask

  task automatic test_random_traffic();
    write_settle(8'd1);
    gaps_on = 1'b0;
    run_traffic(250);
    gaps_on = 1'b1;
    write_settle(8'd3);
    run_traffic(250);
    write_settle(8'd0);
    run_traffic(250);
    write_settle(8'($urandom_range(4, 12)));
    run_traffic(250);
  endtask

  task automatic test_settle_max();
    write_settle(8'd255);
    push_beat(mk(afl_pkg::CmdRxByte, 1'b1, 1'b1, 1'b1, 1'b1));
    while (lk_settle != 0) push_beat(rand_sample());
    push_beat(mk(afl_pkg::CmdTick, 1'b0, 1'b1, 1'b0, 1'b1));
  endtask

  task automatic test_stall_pressure();
    write_settle(8'd1);
    hold_left = 300;
    run_traffic(100);
    drain_results();
    run_traffic(40);
  endtask

  // result sink: long hold when asked, otherwise a rotating stall pattern
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      sink_cyc++;
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        case ((sink_cyc / 97) % 4)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= (sink_cyc % 5) != 0;
          default: out_ready_i <= $urandom_range(0, 7) != 0;
        endcase
      end
    end
  end

  function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (line_results_q.size() == 0) begin
        $error("result beat with nothing expected: %h", out_o);
        errors++;
      end else begin
        want = line_results_q.pop_front();
        n_checked++;
        if (want.rx_valid) n_rx_bytes++;
        if (want.block_done) n_frames++;
        if (want.aborted) n_aborts++;
        check_field("clk_release", 32'(want.clk_release), 32'(out_o.clk_release));
        check_field("data_release", 32'(want.data_release), 32'(out_o.data_release));
        check_field("rx_value", 32'(want.rx_value), 32'(out_o.rx_value));
        check_field("rx_valid", 32'(want.rx_valid), 32'(out_o.rx_valid));
        check_field("need_data", 32'(want.need_data), 32'(out_o.need_data));
        check_field("block_done", 32'(want.block_done), 32'(out_o.block_done));
        check_field("aborted", 32'(want.aborted), 32'(out_o.aborted));
        check_field("busy_res", 32'(want.busy_res), 32'(out_o.busy_res));
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_i        = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_settle();
    test_directed();
    test_random_traffic();
    test_settle_max();
    test_stall_pressure();

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("checked %0d line samples: %0d bytes received, %0d frames sent, %0d aborts",
             n_checked, n_rx_bytes, n_frames, n_aborts);
    $display("settle counts 2 (reset), 0, 1, 3, random and 255, with bursty input and stalls");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
